### hw/rtl/arxp_pkg.sv
package arxp_pkg;

    // Field widths of the stream and configuration channels
    localparam int ACTION_W    = 2;
    localparam int COEF_IDX_W  = 7;
    localparam int DATA_W      = 32;
    localparam int LAG_W       = 5;
    localparam int NIN_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int NUM_CH_FLDS = 4;
    localparam int S_TDATA_W   = 200;
    localparam int FRAC_BITS   = 16;

    // tdata bit positions of the input item
    localparam int TD_IDX_LSB  = 0;
    localparam int TD_COEF_LSB = TD_IDX_LSB + COEF_IDX_W;
    localparam int TD_MEAS_LSB = TD_COEF_LSB + DATA_W;
    localparam int TD_CH0_LSB  = TD_MEAS_LSB + DATA_W;

    // Item actions (code 3 has no meaning and is dropped)
    localparam logic [ACTION_W-1:0] ACT_SAMPLE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_OUT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_IN  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LAGS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LAGS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS_USED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DELAY = 2'd3;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_REDUCE = 9'b000000100,
        ST_INPUT  = 9'b000001000,
        ST_OUTPUT = 9'b000010000,
        ST_DRAIN  = 9'b000100000,
        ST_PUSH_Y = 9'b001000000,
        ST_PUSH_U = 9'b010000000,
        ST_RESULT = 9'b100000000
    } t_state;

    // One tap issued to the multiply-accumulate pipeline
    typedef struct packed {
        logic valid;
        logic neg;
    } t_tap_ctl;

    // Status and result of the multiply-accumulate pipeline
    typedef struct packed {
        logic              busy;
        logic              sat;
        logic [DATA_W-1:0] value;
    } t_mac_res;

endpackage

### hw/rtl/arx_model_predictor.sv
// Operation: a sample first reduces its dead time modulo the ring when it reaches MAX_LAGS,
//   then the single shared multiplier walks one tap per cycle through two memories.
// Samples: a new sample is accepted only once the last result is registered.
// Loads are taken back to back.
// Reset: i_rst_n is synchronous, active low; a clearing pass then zeroes both memories
//   with tready low.
module arx_model_predictor #(
    parameter int MAX_LAGS   = 32,
    parameter int NUM_INPUTS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [6:0] coef_index, [38:7] coef_value, [70:39] measured_output,
    // [102:71] input_ch0, [134:103] input_ch1, [166:135] input_ch2,
    // [198:167] input_ch3, [199] zero
    input  logic [arxp_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // [1:0] action
    input  logic [arxp_pkg::ACTION_W-1:0]       i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] predicted_output
    output logic [arxp_pkg::DATA_W-1:0]         o_m_axis_tdata,
    // [0] saturated
    output logic [0:0]                          o_m_axis_tuser,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [arxp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arxp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import arxp_pkg::*;

    // Both memories share one map: output taps/history at [0, MAX_LAGS),
    // input coefficients at MAX_LAGS + input*(nb+1) + lag,
    // input history at MAX_LAGS + slot*NUM_INPUTS + channel.
    localparam int DEPTH  = MAX_LAGS * (NUM_INPUTS + 1);
    localparam int AW     = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(MAX_LAGS);
    localparam int CH_W   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int CI_W   = $clog2(MAX_LAGS * NUM_INPUTS);
    localparam int ACC_W  = 2 * DATA_W + AW + 1;

    // ---------------------------------------------------------------
    // Handshakes and field unpacking
    // ---------------------------------------------------------------
    logic                  s_accept;
    logic                  m_accept;
    logic                  cfg_accept;
    logic [ACTION_W-1:0]   s_action;
    logic [COEF_IDX_W-1:0] s_idx;
    logic [DATA_W-1:0]     s_coef;
    logic [DATA_W-1:0]     s_meas;
    logic [DATA_W-1:0]     s_u [NUM_CH_FLDS];

    assign s_accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign m_accept   = o_m_axis_tvalid & i_m_axis_tready;
    assign cfg_accept = i_cfg_valid & o_cfg_ready;
    assign s_action   = i_s_axis_tuser;
    assign s_idx      = i_s_axis_tdata[TD_IDX_LSB +: COEF_IDX_W];
    assign s_coef     = i_s_axis_tdata[TD_COEF_LSB +: DATA_W];
    assign s_meas     = i_s_axis_tdata[TD_MEAS_LSB +: DATA_W];

    for (genvar k = 0; k < NUM_CH_FLDS; k++) begin : g_unpack
        assign s_u[k] = i_s_axis_tdata[TD_CH0_LSB + k*DATA_W +: DATA_W];
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic [LAG_W-1:0]    r_na, n_na;
    logic [LAG_W-1:0]    r_nb, n_nb;
    logic [NIN_W-1:0]    r_nin, n_nin;
    logic [LAG_W-1:0]    r_nk, n_nk;
    logic [SLOT_W-1:0]   r_pos, n_pos;
    logic [AW-1:0]       r_clr, n_clr;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SLOT_W-1:0]   r_start, n_start;
    logic [CH_W-1:0]     r_ch, n_ch;
    logic [LAG_W-1:0]    r_tap, n_tap;
    logic [CI_W-1:0]     r_cidx, n_cidx;
    logic [LAG_W-1:0]    r_nkr, n_nkr;
    logic [DATA_W-1:0]   r_y, n_y;
    logic [DATA_W-1:0]   r_u [NUM_CH_FLDS];
    logic [DATA_W-1:0]   n_u [NUM_CH_FLDS];
    logic [DATA_W-1:0]   r_res_value, n_res_value;
    logic                r_res_sat, n_res_sat;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic                r_out_sat, n_out_sat;

    // ---------------------------------------------------------------
    // Memory ports and pipeline hookup
    // ---------------------------------------------------------------
    logic              coef_we;
    logic [AW-1:0]     coef_waddr;
    logic [DATA_W-1:0] coef_wdata;
    logic [AW-1:0]     coef_raddr;
    logic [DATA_W-1:0] coef_rdata;
    logic              hist_we;
    logic [AW-1:0]     hist_waddr;
    logic [DATA_W-1:0] hist_wdata;
    logic [AW-1:0]     hist_raddr;
    logic [DATA_W-1:0] hist_rdata;
    t_tap_ctl          tap;
    logic              mac_clear;
    t_mac_res          mac_res;

    arxp_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    arxp_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    arxp_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (mac_clear),
        .i_tap   (tap),
        .i_coef  (coef_rdata),
        .i_hist  (hist_rdata),
        .o_res   (mac_res)
    );

    // ---------------------------------------------------------------
    // Effective configuration: out-of-range settings fall back
    // ---------------------------------------------------------------
    logic [LAG_W-1:0]    na_eff;
    logic [LAG_W-1:0]    nb_eff;
    logic [NIN_W-1:0]    nin_eff;
    logic                last_ch;
    logic                last_slot0;
    logic [SLOT_W-1:0]   slot_dec;
    logic [SLOT_W-1:0]   pos_dec;
    logic [SLOT_W+1:0]   start_sum;
    logic [SLOT_W-1:0]   start_slot;
    logic [CH_W+1:0]     ch_ext;
    logic [DATA_W-1:0]   push_u;

    assign na_eff  = (32'(r_na) < MAX_LAGS) ? r_na : '0;
    assign nb_eff  = (32'(r_nb) < MAX_LAGS) ? r_nb : '0;
    assign nin_eff = (r_nin != '0 && 32'(r_nin) <= NUM_INPUTS) ? r_nin : NIN_W'(1);
    assign last_ch = (4'(r_ch) == (4'(nin_eff) - 4'd1));

    // step one slot back around the ring
    assign last_slot0 = (r_slot == '0);
    assign slot_dec   = last_slot0 ? SLOT_W'(MAX_LAGS - 1) : (r_slot - 1'b1);
    assign pos_dec    = (r_pos == '0) ? SLOT_W'(MAX_LAGS - 1) : (r_pos - 1'b1);

    // first input slot: pos - 1 - nk around the ring, nk already reduced
    assign start_sum  = (SLOT_W+2)'(r_pos) + (SLOT_W+2)'(MAX_LAGS - 1)
                      - (SLOT_W+2)'(r_nkr);
    assign start_slot = (32'(start_sum) >= MAX_LAGS)
                      ? SLOT_W'(start_sum - (SLOT_W+2)'(MAX_LAGS))
                      : SLOT_W'(start_sum);

    // channels beyond the four item fields push zero
    assign ch_ext = (CH_W+2)'(r_ch);
    assign push_u = (32'(ch_ext) < NUM_CH_FLDS) ? r_u[ch_ext[1:0]] : '0;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_na        = r_na;
        n_nb        = r_nb;
        n_nin       = r_nin;
        n_nk        = r_nk;
        n_pos       = r_pos;
        n_clr       = r_clr;
        n_slot      = r_slot;
        n_start     = r_start;
        n_ch        = r_ch;
        n_tap       = r_tap;
        n_cidx      = r_cidx;
        n_nkr       = r_nkr;
        n_y         = r_y;
        n_u         = r_u;
        n_res_value = r_res_value;
        n_res_sat   = r_res_sat;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_sat   = r_out_sat;

        coef_we    = 1'b0;
        coef_waddr = '0;
        coef_wdata = '0;
        coef_raddr = '0;
        hist_we    = 1'b0;
        hist_waddr = '0;
        hist_wdata = '0;
        hist_raddr = '0;
        tap        = '0;
        mac_clear  = 1'b0;

        // configuration writes land whenever offered
        if (cfg_accept) begin
            unique case (i_cfg_index)
                CFG_OUTPUT_LAGS: n_na  = i_cfg_data[LAG_W-1:0];
                CFG_INPUT_LAGS:  n_nb  = i_cfg_data[LAG_W-1:0];
                CFG_INPUTS_USED: n_nin = i_cfg_data[NIN_W-1:0];
                CFG_INPUT_DELAY: n_nk  = i_cfg_data[LAG_W-1:0];
            endcase
        end

        // the result register empties on a taken transaction
        if (m_accept) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                // zero one entry of each memory per cycle
                coef_we    = 1'b1;
                coef_waddr = r_clr;
                hist_we    = 1'b1;
                hist_waddr = r_clr;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_action)
                        ACT_SAMPLE: begin
                            mac_clear = 1'b1;
                            n_nkr     = r_nk;
                            n_y       = s_meas;
                            n_u       = s_u;
                            n_state   = ST_REDUCE;
                        end
                        ACT_LOAD_OUT: begin
                            coef_we    = (32'(s_idx) < MAX_LAGS);
                            coef_waddr = AW'(s_idx);
                            coef_wdata = s_coef;
                        end
                        ACT_LOAD_IN: begin
                            coef_we    = (32'(s_idx) < MAX_LAGS * NUM_INPUTS);
                            coef_waddr = AW'(MAX_LAGS) + AW'(s_idx);
                            coef_wdata = s_coef;
                        end
                        default: ;  // unused action: drop
                    endcase
                end
            end
            ST_REDUCE: begin
                // take the dead time modulo the ring, one subtract a cycle
                if (32'(r_nkr) >= MAX_LAGS) begin
                    n_nkr = r_nkr - LAG_W'(MAX_LAGS);
                end else begin
                    n_slot  = start_slot;
                    n_start = start_slot;
                    n_ch    = '0;
                    n_tap   = '0;
                    n_cidx  = '0;
                    n_state = ST_INPUT;
                end
            end
            ST_INPUT: begin
                coef_raddr = AW'(MAX_LAGS) + AW'(r_cidx);
                hist_raddr = AW'(MAX_LAGS) + AW'(r_slot) * AW'(NUM_INPUTS) + AW'(r_ch);
                tap.valid  = 1'b1;
                tap.neg    = 1'b0;
                n_cidx     = r_cidx + 1'b1;
                n_slot     = slot_dec;
                if (r_tap == nb_eff) begin
                    n_tap  = '0;
                    n_slot = r_start;
                    if (last_ch) begin
                        n_slot  = pos_dec;
                        n_state = (na_eff == '0) ? ST_DRAIN : ST_OUTPUT;
                    end else begin
                        n_ch = r_ch + 1'b1;
                    end
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            ST_OUTPUT: begin
                coef_raddr = AW'(r_tap);
                hist_raddr = AW'(r_slot);
                tap.valid  = 1'b1;
                tap.neg    = 1'b1;
                n_slot     = slot_dec;
                n_tap      = r_tap + 1'b1;
                if (r_tap == (na_eff - 1'b1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last product to reach the accumulator
                if (!mac_res.busy) begin
                    n_res_value = mac_res.value;
                    n_res_sat   = mac_res.sat;
                    n_ch        = '0;
                    n_state     = ST_PUSH_Y;
                end
            end
            ST_PUSH_Y: begin
                hist_we    = 1'b1;
                hist_waddr = AW'(r_pos);
                hist_wdata = r_y;
                n_state    = ST_PUSH_U;
            end
            ST_PUSH_U: begin
                hist_we    = 1'b1;
                hist_waddr = AW'(MAX_LAGS) + AW'(r_pos) * AW'(NUM_INPUTS) + AW'(r_ch);
                hist_wdata = push_u;
                if (last_ch) begin
                    n_state = ST_RESULT;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            ST_RESULT: begin
                // hold until the result register is free or being taken
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res_value;
                    n_out_sat   = r_res_sat;
                    n_pos       = (32'(r_pos) == MAX_LAGS - 1) ? '0 : (r_pos + 1'b1);
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_na        <= '0;
            r_nb        <= '0;
            r_nin       <= NIN_W'(1);
            r_nk        <= '0;
            r_pos       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_na        <= n_na;
            r_nb        <= n_nb;
            r_nin       <= n_nin;
            r_nk        <= n_nk;
            r_pos       <= n_pos;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_start     <= n_start;
        r_ch        <= n_ch;
        r_tap       <= n_tap;
        r_cidx      <= n_cidx;
        r_nkr       <= n_nkr;
        r_y         <= n_y;
        r_u         <= n_u;
        r_res_value <= n_res_value;
        r_res_sat   <= n_res_sat;
        r_out_data  <= n_out_data;
        r_out_sat   <= n_out_sat;
    end

    // ---------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;
    assign o_cfg_ready     = 1'b1;

endmodule

### hw/rtl/arxp_ram.sv
module arxp_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/arxp_mac.sv
module arxp_mac #(
    parameter int ACC_W = 80
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_clear,
    input  arxp_pkg::t_tap_ctl               i_tap,
    input  logic [arxp_pkg::DATA_W-1:0]      i_coef,
    input  logic [arxp_pkg::DATA_W-1:0]      i_hist,
    output arxp_pkg::t_mac_res               o_res
);
    import arxp_pkg::*;

    localparam int SH_W = ACC_W - FRAC_BITS;

    logic                       r_s1_v;
    logic                       r_s1_neg;
    logic                       r_s2_v;
    logic                       r_s2_neg;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [2*DATA_W-1:0] n_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [SH_W-1:0]     shifted;
    logic [SH_W-DATA_W:0]       upper;
    logic                       fits;

    assign n_prod   = $signed(i_coef) * $signed(i_hist);
    assign prod_ext = {{(ACC_W-2*DATA_W){r_prod[2*DATA_W-1]}}, r_prod};

    always_comb begin
        n_acc = r_acc;
        if (i_clear) begin
            n_acc = '0;
        end else if (r_s2_v) begin
            n_acc = r_s2_neg ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_tap.valid;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_neg <= i_tap.neg;
        r_s2_neg <= r_s1_neg;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
    end

    // floor shift, then clip when the upper bits are not a sign extension
    assign shifted = SH_W'(r_acc >>> FRAC_BITS);
    assign upper   = shifted[SH_W-1:DATA_W-1];
    assign fits    = (&upper) | ~(|upper);

    assign o_res.busy  = r_s1_v | r_s2_v;
    assign o_res.sat   = ~fits;
    assign o_res.value = fits ? shifted[DATA_W-1:0]
                              : (r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX);

endmodule

### hw/rtl/arxp_checker.sv
module arxp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic [arxp_pkg::ACTION_W-1:0]       i_s_axis_tuser,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [arxp_pkg::DATA_W-1:0]         o_m_axis_tdata,
    input logic [0:0]                          o_m_axis_tuser
);
    import arxp_pkg::*;

    logic s_accept;

    assign s_accept = i_s_axis_tvalid & o_s_axis_tready;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result payload changed while stalled");

    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            (o_m_axis_tdata == SAT_MAX || o_m_axis_tdata == SAT_MIN))
        else $error("saturated flag without a clipped value");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_axis_tuser == ACT_SAMPLE |=> !o_s_axis_tready)
        else $error("sample transaction did not start the walk");

    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (i_s_axis_tuser == ACT_LOAD_OUT || i_s_axis_tuser == ACT_LOAD_IN)
            |=> o_s_axis_tready)
        else $error("load transaction did not complete in one cycle");

endmodule

bind arx_model_predictor arxp_checker u_arxp_checker (.*);
